### rtl/rng_pkg.sv
// Shared constants and types for the three-channel ultrasonic ranger.
package rng_pkg;

  // Default sizing of the block.
  localparam int TICKS_PER_MS_DEF = 1000;
  localparam int CHANNELS_DEF = 3;
  localparam int IO_CHANNELS = 3;

  // Trigger pulse shape in ticks.
  localparam int LOW_TICKS = 2;
  localparam int HIGH_TICKS = 10;
  localparam int PHASE_W = 4;

  // Field and register widths.
  localparam int TICKS_W = 16;
  localparam int DIST_W = 15;
  localparam int MS_W = 10;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [TICKS_W-1:0] TIMEOUT_RST = 16'd30000;
  localparam logic [DIST_W-1:0] FREE_RST = 15'd6400;
  localparam logic [DIST_W-1:0] WALL_RST = 15'd240;
  localparam logic [MS_W-1:0] INTERVAL_RST = 10'd20;

  // Distance in 1/16 cm is floor((d * 343 + 625) / 1250), which rounds
  // d * 0.2744 with halves going up. The divide by 1250 is a multiply by
  // floor(2^25 / 1250) and a single correction step.
  localparam int NUM_W = 25;
  localparam logic [NUM_W-1:0] MUL_NUM = 25'd343;
  localparam logic [NUM_W-1:0] ADD_NUM = 25'd625;
  localparam logic [NUM_W-1:0] DIV_DEN = 25'd1250;
  localparam int RECIP_W = 15;
  localparam logic [RECIP_W-1:0] RECIP = 15'd26843;
  localparam int RECIP_SHIFT = 25;
  localparam int PROD_W = NUM_W + RECIP_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_FREE     = 2'd1,
    REG_WALL     = 2'd2,
    REG_INTERVAL = 2'd3
  } cfg_reg_t;

  // Pipeline advance controls shared by the lanes.
  typedef struct packed {
    logic accept;
    logic adv2;
    logic commit;
  } pipe_ctl_t;

endpackage

### rtl/rng_if.sv
// Request channel interfaces of the ranger: echo samples in, range reports out.
interface rng_in_if ();
  logic valid;
  logic ready;
  logic echo_front;
  logic echo_left;
  logic echo_right;

  modport source (output valid, output echo_front, output echo_left,
                  output echo_right, input ready);
  modport sink (input valid, input echo_front, input echo_left,
                input echo_right, output ready);
endinterface

interface rng_out_if import rng_pkg::*; ();
  logic valid;
  logic ready;
  logic trig_front;
  logic trig_left;
  logic trig_right;
  logic [DIST_W-1:0] dist_front;
  logic [DIST_W-1:0] dist_left;
  logic [DIST_W-1:0] dist_right;
  logic wall_front;
  logic wall_left;
  logic wall_right;

  modport source (output valid, output trig_front, output trig_left, output trig_right,
                  output dist_front, output dist_left, output dist_right,
                  output wall_front, output wall_left, output wall_right, input ready);
  modport sink (input valid, input trig_front, input trig_left, input trig_right,
                input dist_front, input dist_left, input dist_right,
                input wall_front, input wall_left, input wall_right, output ready);
endinterface

### rtl/rng_lane.sv
// One echo channel: edge tracking, duration count and distance conversion.
module rng_lane import rng_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              echo,
  input  pipe_ctl_t         ctl,
  input  logic [TICKS_W-1:0] timeout,
  input  logic [DIST_W-1:0] free_dist,
  output logic [DIST_W-1:0] dist_next
);

  logic              echo_last;
  logic              measuring;
  logic [TICKS_W-1:0] pulse_ticks;
  logic              fall;

  logic              s1_fall;
  logic              s1_free;
  logic [NUM_W-1:0]  s1_num;
  logic [PROD_W-1:0] prod;

  logic              s2_fall;
  logic              s2_free;
  logic [NUM_W-1:0]  s2_num;
  logic [DIST_W-1:0] s2_q0;
  logic [NUM_W-1:0]  rem;
  logic [DIST_W-1:0] quot;

  logic [DIST_W-1:0] distance;

  // A falling edge closes a running measurement.
  assign fall = !echo && echo_last && measuring;

  // Edge detection and saturating duration count, once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_last   <= 1'b0;
      measuring   <= 1'b0;
      pulse_ticks <= '0;
    end else if (ctl.accept) begin
      echo_last <= echo;
      if (echo && !echo_last) begin
        measuring   <= 1'b1;
        pulse_ticks <= TICKS_W'(1);
      end else if (echo && measuring) begin
        if (pulse_ticks != '1) begin
          pulse_ticks <= pulse_ticks + 1'b1;
        end
      end else if (fall) begin
        measuring <= 1'b0;
      end
    end
  end

  // Stage one: range check and scaled numerator of the duration.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_fall <= fall;
      s1_free <= !((pulse_ticks != '0) && (pulse_ticks < timeout));
      s1_num  <= NUM_W'(pulse_ticks) * MUL_NUM + ADD_NUM;
    end
  end

  // Stage two: reciprocal multiply gives the quotient, possibly one short.
  assign prod = PROD_W'(s1_num) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      s2_fall <= s1_fall;
      s2_free <= s1_free;
      s2_num  <= s1_num;
      s2_q0   <= prod[RECIP_SHIFT +: DIST_W];
    end
  end

  // Correction step and selection of the new distance.
  assign rem  = s2_num - NUM_W'(s2_q0) * DIV_DEN;
  assign quot = s2_q0 + DIST_W'(rem >= DIV_DEN);

  always_comb begin
    dist_next = distance;
    if (ctl.commit && s2_fall) begin
      dist_next = s2_free ? free_dist : quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance <= FREE_RST;
    end else if (ctl.commit) begin
      distance <= dist_next;
    end
  end

endmodule

### rtl/rng_trigger.sv
// Millisecond timebase and round-robin trigger pulse sequencer.
module rng_trigger import rng_pkg::*; #(
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [MS_W-1:0]     interval,
  output logic [CHANNELS-1:0] trig
);

  localparam int TICK_W = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;
  localparam int TURN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TICK_W-1:0]  tick_in_ms;
  logic [TICK_W-1:0]  tick_in_ms_next;
  logic [MS_W-1:0]    ms_since_trigger;
  logic [MS_W-1:0]    ms_since_trigger_next;
  logic [PHASE_W-1:0] trigger_phase;
  logic [PHASE_W-1:0] trigger_phase_next;
  logic [PHASE_W-1:0] phase_now;
  logic [TURN_W-1:0]  turn;
  logic [TURN_W-1:0]  turn_next;

  // Advance the timebase, start a pulse when due, and step the pulse.
  always_comb begin
    tick_in_ms_next       = tick_in_ms + 1'b1;
    ms_since_trigger_next = ms_since_trigger;
    phase_now             = trigger_phase;
    trigger_phase_next    = '0;
    turn_next             = turn;
    trig                  = '0;
    if (tick_in_ms == TICK_W'(TICKS_PER_MS - 1)) begin
      tick_in_ms_next = '0;
      if (ms_since_trigger != '1) begin
        ms_since_trigger_next = ms_since_trigger + 1'b1;
      end
    end
    if ((trigger_phase == '0) && (ms_since_trigger_next >= interval)) begin
      ms_since_trigger_next = '0;
      phase_now             = PHASE_W'(1);
    end
    if (phase_now != '0) begin
      if (phase_now > PHASE_W'(LOW_TICKS)) begin
        trig[turn] = 1'b1;
      end
      trigger_phase_next = phase_now + 1'b1;
      if (trigger_phase_next > PHASE_W'(LOW_TICKS + HIGH_TICKS)) begin
        trigger_phase_next = '0;
        turn_next = (turn == TURN_W'(CHANNELS - 1)) ? '0 : turn + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_in_ms       <= '0;
      ms_since_trigger <= '0;
      trigger_phase    <= '0;
      turn             <= '0;
    end else if (accept) begin
      tick_in_ms       <= tick_in_ms_next;
      ms_since_trigger <= ms_since_trigger_next;
      trigger_phase    <= trigger_phase_next;
      turn             <= turn_next;
    end
  end

endmodule

### rtl/three_channel_ultrasonic_ranger.sv
// Top level of the three-channel ultrasonic ranger.
// Each request on samples is one microsecond tick carrying the three echo
// levels; the block takes one request every clock cycle when not stalled
// and returns one report per request, in order. A request passes through
// the two-stage distance conversion of each channel lane (scaled numerator,
// then reciprocal multiply), the correction step and the output register.
// The block stalls only when the report side stalls and its three pipeline
// stages are full. Every report carries the trigger levels for that tick
// and the distances and wall flags that already include any echo edges
// seen in that tick. The user must write the configuration through cfg_we,
// cfg_index and cfg_data only while no requests are in flight (unenforced).
module three_channel_ultrasonic_ranger import rng_pkg::*; #(
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEF,
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  rng_in_if.sink               samples,
  rng_out_if.source            results
);

  logic [TICKS_W-1:0] timeout_ticks;
  logic [DIST_W-1:0]  free_distance;
  logic [DIST_W-1:0]  wall_distance;
  logic [MS_W-1:0]    trigger_interval_ms;

  logic      v1;
  logic      v2;
  logic      out_valid;
  logic      adv_out;
  logic      ready2;
  logic      ready1;
  pipe_ctl_t ctl;

  logic [IO_CHANNELS-1:0] echo_io;
  logic [CHANNELS-1:0]    trig_now;
  logic [CHANNELS-1:0]    s1_trig;
  logic [CHANNELS-1:0]    s2_trig;
  logic [DIST_W-1:0]      lane_dist [CHANNELS];

  logic [IO_CHANNELS-1:0] io_trig;
  logic [DIST_W-1:0]      io_dist [IO_CHANNELS];
  logic [IO_CHANNELS-1:0] out_trig;
  logic [DIST_W-1:0]      out_dist [IO_CHANNELS];
  logic [IO_CHANNELS-1:0] out_wall;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks       <= TIMEOUT_RST;
      free_distance       <= FREE_RST;
      wall_distance       <= WALL_RST;
      trigger_interval_ms <= INTERVAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TIMEOUT:  timeout_ticks       <= cfg_data[TICKS_W-1:0];
        REG_FREE:     free_distance       <= cfg_data[DIST_W-1:0];
        REG_WALL:     wall_distance       <= cfg_data[DIST_W-1:0];
        REG_INTERVAL: trigger_interval_ms <= cfg_data[MS_W-1:0];
        default:      ;
      endcase
    end
  end

  // Pipeline flow control: each stage moves when the one after it has room.
  assign adv_out       = !out_valid || results.ready;
  assign ready2        = !v2 || adv_out;
  assign ready1        = !v1 || ready2;
  assign samples.ready = ready1;
  assign ctl.accept    = samples.valid && ready1;
  assign ctl.adv2      = ready2;
  assign ctl.commit    = v2 && adv_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= samples.valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (adv_out) begin
        out_valid <= v2;
      end
    end
  end

  // Trigger sequencer and its delay line to match the lanes.
  rng_trigger #(
    .TICKS_PER_MS (TICKS_PER_MS),
    .CHANNELS     (CHANNELS)
  ) u_trigger (
    .clk      (clk),
    .rst      (rst),
    .accept   (ctl.accept),
    .interval (trigger_interval_ms),
    .trig     (trig_now)
  );

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      s1_trig <= trig_now;
    end
    if (ctl.adv2) begin
      s2_trig <= s1_trig;
    end
  end

  // One lane per channel; channels without an echo pin see a low line.
  assign echo_io = {samples.echo_right, samples.echo_left, samples.echo_front};

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic lane_echo;
    if (c < IO_CHANNELS) begin : g_pin
      assign lane_echo = echo_io[c];
    end else begin : g_nopin
      assign lane_echo = 1'b0;
    end
    rng_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .echo      (lane_echo),
      .ctl       (ctl),
      .timeout   (timeout_ticks),
      .free_dist (free_distance),
      .dist_next (lane_dist[c])
    );
  end

  // Merge the lanes onto the report fields; absent channels report zero.
  for (genvar c = 0; c < IO_CHANNELS; c++) begin : g_merge
    if (c < CHANNELS) begin : g_used
      assign io_trig[c] = s2_trig[c];
      assign io_dist[c] = lane_dist[c];
    end else begin : g_unused
      assign io_trig[c] = 1'b0;
      assign io_dist[c] = '0;
    end

    always_ff @(posedge clk) begin
      if (adv_out) begin
        out_trig[c] <= io_trig[c];
        out_dist[c] <= io_dist[c];
        out_wall[c] <= (c < CHANNELS) && (io_dist[c] < wall_distance);
      end
    end
  end

  // Report outputs.
  assign results.valid      = out_valid;
  assign results.trig_front = out_trig[0];
  assign results.trig_left  = out_trig[1];
  assign results.trig_right = out_trig[2];
  assign results.dist_front = out_dist[0];
  assign results.dist_left  = out_dist[1];
  assign results.dist_right = out_dist[2];
  assign results.wall_front = out_wall[0];
  assign results.wall_left  = out_wall[1];
  assign results.wall_right = out_wall[2];

endmodule
